// ----- rtl/core/art_pkg.sv -----
// shared types and constants of the address region table
`timescale 1ns / 1ps

package art_pkg;

    localparam int ADDR_W   = 64;
    localparam int RIGHTS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int STAT_W   = 2;

    // request kind carried on tuser
    localparam logic MODE_DEFINE = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_OVERLAP = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISS    = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [1:0] {
        ART_IDLE,
        ART_CMP,
        ART_DONE
    } art_state_t;

    // control broadcast to every cell
    typedef struct packed {
        logic cmp_en;
        logic commit;
    } cell_ctrl_t;

    // priority chain passed from cell to cell, lowest slot first
    typedef struct packed {
        logic                hit_seen;
        logic                free_seen;
        logic                olap_any;
        logic [RIGHTS_W-1:0] rights;
        logic [SLOT_W-1:0]   hit_slot;
        logic [SLOT_W-1:0]   free_slot;
    } chain_t;

endpackage

// ----- rtl/core/art_cell.sv -----
// one region slot: stored range, compare flags and its link in the priority chain
`timescale 1ns / 1ps

module art_cell
    import art_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cell_ctrl_t          ctrl,
    input  logic [ADDR_W-1:0]   base,
    input  logic [ADDR_W-1:0]   top,
    input  logic [RIGHTS_W-1:0] rights,
    input  chain_t              chain_in,
    output chain_t              chain_out
);

    localparam logic [SLOT_W-1:0] SLOT_ID = SLOT_W'(IDX);

    logic [ADDR_W-1:0]   low_reg;
    logic [ADDR_W-1:0]   high_reg;
    logic [RIGHTS_W-1:0] rights_reg;
    logic                used_reg;
    logic                hit_reg;
    logic                olap_reg;

    logic base_in, top_in, low_in;
    logic hit_next, olap_next;
    logic sel_hit, sel_free;

    // range tests against the stored region
    always_comb begin
        base_in   = (base >= low_reg) && (base <= high_reg);
        top_in    = (top >= low_reg) && (top <= high_reg);
        low_in    = (low_reg >= base) && (low_reg <= top);
        hit_next  = used_reg && base_in;
        olap_next = used_reg && (base_in || top_in || low_in);
    end

    // compare flags
    always_ff @(posedge aclk) begin
        if (ctrl.cmp_en) begin
            hit_reg  <= hit_next;
            olap_reg <= olap_next;
        end
    end

    // chain link: lowest hit and lowest free slot win
    always_comb begin
        sel_hit  = hit_reg && !chain_in.hit_seen;
        sel_free = !used_reg && !chain_in.free_seen;
        chain_out           = chain_in;
        chain_out.hit_seen  = chain_in.hit_seen || hit_reg;
        chain_out.free_seen = chain_in.free_seen || !used_reg;
        chain_out.olap_any  = chain_in.olap_any || olap_reg;
        if (sel_hit) begin
            chain_out.rights   = rights_reg;
            chain_out.hit_slot = SLOT_ID;
        end
        if (sel_free) begin
            chain_out.free_slot = SLOT_ID;
        end
    end

    // region store
    always_ff @(posedge aclk) begin
        if (ctrl.commit && sel_free) begin
            low_reg    <= base;
            high_reg   <= top;
            rights_reg <= rights;
        end
    end

    // valid mark
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
        end else if (ctrl.commit && sel_free) begin
            used_reg <= 1'b1;
        end
    end

endmodule

// ----- rtl/core/address_region_table.sv -----
// top level of the address region table
`timescale 1ns / 1ps

// Address region table with MAX_REGIONS slots, one cell per slot. A request
// passes the sequencer states in order: in the idle state it is taken and its
// region top is formed, in the compare state every cell compares it against its
// stored range, and in the done state the priority chain through the cells picks
// the lowest matching or free slot and, once the output side is free, the result
// is registered. A new request is taken whenever the sequencer is idle, even
// while the previous result still waits on the master side. Define requests go
// on tuser = 0, lookups on tuser = 1. The valid marks clear at reset; no sweep.

module address_region_table
    import art_pkg::*;
#(
    parameter int MAX_REGIONS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,  // address[63:0], span[127:64], access_rights[130:128]
    input  logic         s_tuser,  // mode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata   // status[1:0], rights_found[4:2], slot[8:5]
);

    art_state_t state_reg, state_next;

    logic                mode_reg;
    logic [ADDR_W-1:0]   base_reg;
    logic [ADDR_W-1:0]   top_reg;
    logic [RIGHTS_W-1:0] rights_reg;

    logic                m_valid_reg, m_valid_next;
    status_t             status_reg, status_next;
    logic [RIGHTS_W-1:0] rfound_reg, rfound_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;

    cell_ctrl_t ctrl;
    chain_t     chain [0:MAX_REGIONS];
    chain_t     tail;
    logic       accept;
    logic       out_free;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // request capture, top wraps modulo 2^64
    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg   <= s_tuser;
            base_reg   <= s_tdata[63:0];
            top_reg    <= s_tdata[63:0] + s_tdata[127:64];
            rights_reg <= s_tdata[130:128];
        end
    end

    // cell row
    assign chain[0] = '0;

    for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
        art_cell #(
            .IDX(g)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .base     (base_reg),
            .top      (top_reg),
            .rights   (rights_reg),
            .chain_in (chain[g]),
            .chain_out(chain[g+1])
        );
    end

    assign tail = chain[MAX_REGIONS];

    // sequencer next state and result
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        status_next  = status_reg;
        rfound_next  = rfound_reg;
        slot_next    = slot_reg;
        ctrl         = '0;
        s_tready     = 1'b0;
        case (state_reg)
            ART_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ART_CMP;
                end
            end
            ART_CMP: begin
                ctrl.cmp_en = 1'b1;
                state_next  = ART_DONE;
            end
            ART_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    rfound_next  = '0;
                    slot_next    = '0;
                    if (mode_reg == MODE_LOOKUP) begin
                        if (tail.hit_seen) begin
                            status_next = ST_OK;
                            rfound_next = tail.rights;
                            slot_next   = tail.hit_slot;
                        end else begin
                            status_next = ST_MISS;
                        end
                    end else if (!tail.free_seen) begin
                        status_next = ST_FULL;
                    end else if (tail.olap_any) begin
                        status_next = ST_OVERLAP;
                    end else begin
                        status_next = ST_OK;
                        slot_next   = tail.free_slot;
                        ctrl.commit = 1'b1;
                    end
                    state_next = ART_IDLE;
                end
            end
            default: begin
                state_next = ART_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ART_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        rfound_reg <= rfound_next;
        slot_reg   <= slot_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, slot_reg, rfound_reg, status_reg};

endmodule
